[design/fixed_point_alu_macros.svh]
// ---------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Shared concurrent assertion wrappers, switched off by ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

`ifndef ASSERT_OFF
// property that must hold at every rising clock edge outside reset
`define FPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fixed_point_alu: assertion failed");
// condition that must never be seen outside reset
`define FPA_ASSERT_NEVER(lbl, cond) \
  `FPA_ASSERT(lbl, !(cond))
`else
`define FPA_ASSERT(lbl, prop)
`define FPA_ASSERT_NEVER(lbl, cond)
`endif

`endif

[design/fpa_pkg.sv]
// ---------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes, beat payload types, divider control word and result clamp.
// ---------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRACTION_BITS = 8;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } fpa_op_e;

  typedef struct packed {
    fpa_op_e            opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               saturated;
    logic               divide_by_zero;
  } fpa_out_t;

  // control word that travels alongside the divider state
  typedef struct packed {
    fpa_op_e     op;
    logic [31:0] res;
    logic        cmp;
    logic        sat;
    logic        dz;
    logic        neg;
  } fpa_ctl_t;

  typedef struct packed {
    logic [31:0] res;
    logic        sat;
  } fpa_clamp_t;

  localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;
  localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN   = 32'h8000_0000;

  // apply sign to a magnitude and clamp to the signed 32-bit range
  function automatic fpa_clamp_t fpa_clamp(input logic [63:0] mag, input logic neg);
    fpa_clamp_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > NEG_LIMIT) begin
        r.sat = 1'b1;
        r.res = S32_MIN;
      end else begin
        r.res = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > POS_LIMIT) begin
        r.sat = 1'b1;
        r.res = S32_MAX;
      end else begin
        r.res = mag[31:0];
      end
    end
    return r;
  endfunction

endpackage

[design/fpa_cell.sv]
// ---------------------------------------------------------------------------
// Fixed-point ALU divider cell
// One restoring division step per cell; carries the beat's control word.
// ---------------------------------------------------------------------------
module fpa_cell #(
  parameter int QW = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  fpa_pkg::fpa_ctl_t ctl_i,
  input  logic [31:0]       rem_i,
  input  logic [QW-1:0]     nq_i,
  input  logic [31:0]       den_i,
  output logic              valid_o,
  output fpa_pkg::fpa_ctl_t ctl_o,
  output logic [31:0]       rem_o,
  output logic [QW-1:0]     nq_o,
  output logic [31:0]       den_o
);

  logic              valid_q;
  fpa_pkg::fpa_ctl_t ctl_q;
  logic [31:0]       rem_q, rem_d;
  logic [QW-1:0]     nq_q, nq_d;
  logic [31:0]       den_q;
  logic [32:0]       rem_sh;
  logic [32:0]       diff;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    rem_sh = {rem_i, nq_i[QW-1]};
    diff   = rem_sh - {1'b0, den_i};
    if (rem_sh >= {1'b0, den_i}) begin
      rem_d = diff[31:0];
      nq_d  = {nq_i[QW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[31:0];
      nq_d  = {nq_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_q <= ctl_i;
      rem_q <= rem_d;
      nq_q  <= nq_d;
      den_q <= den_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign den_o   = den_q;

endmodule

[design/fixed_point_alu.sv]
// ---------------------------------------------------------------------------
// Fixed-point ALU
// Signed 32-bit Q(32-F).F ALU with a pipelined divider chain.
// ---------------------------------------------------------------------------
// Usage: present a beat (opcode, operand_a, operand_b) on in_i with
// in_valid_i high; it is taken at a rising edge where in_stall_o is low.
// Each beat yields exactly one result beat on out_o, qualified by
// out_valid_o and taken where out_stall_i is low. Results leave in order.
// Stages, the same for every opcode (default format Q24.8):
// one input stage holding operand decode and the 32x32 multiplier, one
// divider cell per quotient bit (restoring division, one bit per cell),
// and one output stage doing divide rounding and clamping.
// Throughput: one beat per cycle unless stalled; all ops share the chain.
// Stalls: each stage advances whenever the stage after it is empty or
// advancing, so bubbles are squeezed out while out_stall_i is high and
// in_stall_o only rises once the whole chain is full.
// Reset: clears all stage valids; the data registers are not reset.
// ---------------------------------------------------------------------------
`include "fixed_point_alu_macros.svh"

module fixed_point_alu #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fpa_pkg::fpa_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fpa_pkg::fpa_out_t out_o
);

  localparam int QW = 32 + FRACTION_BITS;  // quotient bits, one cell each
  localparam int N  = QW;

  // input stage
  logic               v1_q;
  fpa_pkg::fpa_ctl_t  ctl1_q, ctl1_d;
  logic [63:0]        prod1_q, prod1_d;
  logic [QW-1:0]      nq1_q, nq1_d;
  logic [31:0]        den1_q, den1_d;
  logic signed [31:0] a_s, b_s;
  logic [31:0]        amag, bmag;

  // chain
  logic                   vld  [0:N];
  fpa_pkg::fpa_ctl_t      ctl  [0:N];
  logic [31:0]            rem  [0:N];
  logic [QW-1:0]          nq   [0:N];
  logic [31:0]            den  [0:N];
  logic [N:0]             adv;
  logic                   adv_in;

  // multiply finish
  logic [63:0]            mul_mag;
  fpa_pkg::fpa_clamp_t    mul_cl;

  // output stage
  logic                   out_valid_q;
  fpa_pkg::fpa_out_t      out_q, out_d;
  logic                   rnd_up;
  logic [QW:0]            div_q;
  fpa_pkg::fpa_clamp_t    div_cl;

  // -------------------------------------------------------------------------
  // Decode: simple ops finish here, multiply starts, divider is seeded
  // -------------------------------------------------------------------------
  always_comb begin
    a_s  = in_i.operand_a;
    b_s  = in_i.operand_b;
    amag = a_s[31] ? 32'd0 - a_s : a_s;
    bmag = b_s[31] ? 32'd0 - b_s : b_s;

    ctl1_d.op  = in_i.opcode;
    ctl1_d.res = 32'd0;
    ctl1_d.cmp = 1'b0;
    ctl1_d.sat = 1'b0;
    ctl1_d.dz  = 1'b0;
    ctl1_d.neg = a_s[31] ^ b_s[31];

    case (in_i.opcode)
      fpa_pkg::OP_ADD:      ctl1_d.res = a_s + b_s;
      fpa_pkg::OP_SUB:      ctl1_d.res = a_s - b_s;
      fpa_pkg::OP_MUL:      ctl1_d.res = 32'd0;
      fpa_pkg::OP_DIV: begin
        // zero divisor: saturate by the dividend's sign unless it is zero, flag it
        if (b_s == 32'sd0) begin
          ctl1_d.dz = 1'b1;
          if (a_s > 32'sd0) begin
            ctl1_d.res = fpa_pkg::S32_MAX;
            ctl1_d.sat = 1'b1;
          end else if (a_s < 32'sd0) begin
            ctl1_d.res = fpa_pkg::S32_MIN;
            ctl1_d.sat = 1'b1;
          end
        end
      end
      fpa_pkg::OP_GT:       ctl1_d.cmp = a_s >  b_s;
      fpa_pkg::OP_LT:       ctl1_d.cmp = a_s <  b_s;
      fpa_pkg::OP_GE:       ctl1_d.cmp = a_s >= b_s;
      fpa_pkg::OP_LE:       ctl1_d.cmp = a_s <= b_s;
      fpa_pkg::OP_EQ:       ctl1_d.cmp = a_s == b_s;
      fpa_pkg::OP_NE:       ctl1_d.cmp = a_s != b_s;
      fpa_pkg::OP_MIN:      ctl1_d.res = (a_s < b_s) ? a_s : b_s;
      fpa_pkg::OP_MAX:      ctl1_d.res = (a_s > b_s) ? a_s : b_s;
      fpa_pkg::OP_INC:      ctl1_d.res = a_s + 32'sd1;
      fpa_pkg::OP_DEC:      ctl1_d.res = a_s - 32'sd1;
      fpa_pkg::OP_TO_INT:   ctl1_d.res = a_s >>> FRACTION_BITS;
      fpa_pkg::OP_FROM_INT: ctl1_d.res = a_s << FRACTION_BITS;
      default:              ctl1_d.res = 32'd0;
    endcase

    prod1_d = {32'd0, amag} * {32'd0, bmag};
    nq1_d   = {amag, {FRACTION_BITS{1'b0}}};
    den1_d  = bmag;
  end

  // advance when the stage ahead is empty or moving
  assign adv[N]     = !out_valid_q || !out_stall_i;
  assign adv_in     = !v1_q || adv[0];
  assign in_stall_o = !adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_in) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in) begin
      ctl1_q  <= ctl1_d;
      prod1_q <= prod1_d;
      nq1_q   <= nq1_d;
      den1_q  <= den1_d;
    end
  end

  // -------------------------------------------------------------------------
  // Multiply: round half away from zero, clamp; merge into control word
  // -------------------------------------------------------------------------
  always_comb begin
    mul_mag = (prod1_q + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    mul_cl  = fpa_pkg::fpa_clamp(mul_mag, ctl1_q.neg);
    ctl[0]  = ctl1_q;
    if (ctl1_q.op == fpa_pkg::OP_MUL) begin
      ctl[0].res = mul_cl.res;
      ctl[0].sat = mul_cl.sat;
    end
  end

  assign vld[0] = v1_q;
  assign rem[0] = 32'd0;
  assign nq[0]  = nq1_q;
  assign den[0] = den1_q;

  // -------------------------------------------------------------------------
  // Divider chain: one quotient bit per cell
  // -------------------------------------------------------------------------
  for (genvar k = 0; k < N; k++) begin : g_cell
    assign adv[k] = !vld[k+1] || adv[k+1];

    fpa_cell #(
      .QW (QW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv[k]),
      .valid_i (vld[k]),
      .ctl_i   (ctl[k]),
      .rem_i   (rem[k]),
      .nq_i    (nq[k]),
      .den_i   (den[k]),
      .valid_o (vld[k+1]),
      .ctl_o   (ctl[k+1]),
      .rem_o   (rem[k+1]),
      .nq_o    (nq[k+1]),
      .den_o   (den[k+1])
    );
  end

  // -------------------------------------------------------------------------
  // Output stage: round the quotient up when twice the remainder reaches
  // the divisor, then clamp
  // -------------------------------------------------------------------------
  always_comb begin
    rnd_up = {rem[N], 1'b0} >= {1'b0, den[N]};
    div_q  = {1'b0, nq[N]} + {{QW{1'b0}}, rnd_up};
    div_cl = fpa_pkg::fpa_clamp({{(63 - QW){1'b0}}, div_q}, ctl[N].neg);

    out_d.result_value   = ctl[N].res;
    out_d.compare_true   = ctl[N].cmp;
    out_d.saturated      = ctl[N].sat;
    out_d.divide_by_zero = ctl[N].dz;
    if (ctl[N].op == fpa_pkg::OP_DIV && !ctl[N].dz) begin
      out_d.result_value = div_cl.res;
      out_d.saturated    = div_cl.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv[N]) begin
      out_valid_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[N]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `FPA_ASSERT(a_no_stall_when_drained, !out_valid_q |-> !in_stall_o)
  `FPA_ASSERT(a_cmp_zero_result,
              out_valid_q && out_q.compare_true |-> out_q.result_value == 32'sd0)
  `FPA_ASSERT_NEVER(a_cmp_with_flags,
                    out_valid_q && out_q.compare_true &&
                    (out_q.saturated || out_q.divide_by_zero))
  `FPA_ASSERT(a_dz_zero_result,
              out_valid_q && out_q.divide_by_zero && !out_q.saturated
              |-> out_q.result_value == 32'sd0)

endmodule

[dv/tb_fixed_point_alu.sv]
// ---------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed and random operations through the valid/stall channels,
// predicts every result with exact integer arithmetic and checks the
// result beats in order, with random gaps on the input and random stalls
// on the output.
// ---------------------------------------------------------------------------
module tb_fixed_point_alu;
  import fpa_pkg::*;

  localparam int FB = fpa_pkg::FRACTION_BITS;

  // scoreboard: predict on input accept, compare on output accept
  class alu_scoreboard;
    fpa_out_t pending[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // clamp a magnitude with a sign into the signed 32-bit range
    function automatic void clamp(input logic [63:0] m, input bit neg,
                                  ref fpa_out_t r);
      if (neg) begin
        if (m > 64'h8000_0000) begin
          r.saturated = 1'b1;
          r.result_value = 32'h8000_0000;
        end else begin
          r.result_value = -m[31:0];
        end
      end else begin
        if (m > 64'h7FFF_FFFF) begin
          r.saturated = 1'b1;
          r.result_value = 32'h7FFF_FFFF;
        end else begin
          r.result_value = m[31:0];
        end
      end
    endfunction

    function automatic fpa_out_t compute(input fpa_in_t x);
      fpa_out_t r;
      logic signed [31:0] a, b;
      logic [63:0] ma, mb, prod, num, q;
      bit neg;
      a = x.operand_a;
      b = x.operand_b;
      r = '0;
      ma = a[31] ? 64'(-$signed(64'(a))) : 64'(a);
      mb = b[31] ? 64'(-$signed(64'(b))) : 64'(b);
      neg = a[31] != b[31];
      case (x.opcode)
        OP_ADD: r.result_value = a + b;
        OP_SUB: r.result_value = a - b;
        OP_MUL: begin
          prod = ma * mb;
          q = (prod + (64'd1 << (FB - 1))) >> FB;
          clamp(q, neg, r);
        end
        OP_DIV: begin
          if (b == 0) begin
            r.divide_by_zero = 1'b1;
            if (a > 0) begin
              r.saturated = 1'b1;
              r.result_value = 32'h7FFF_FFFF;
            end else if (a < 0) begin
              r.saturated = 1'b1;
              r.result_value = 32'h8000_0000;
            end
          end else begin
            num = ma << FB;
            q = (2 * num + mb) / (2 * mb);
            clamp(q, neg, r);
          end
        end
        OP_GT: r.compare_true = a > b;
        OP_LT: r.compare_true = a < b;
        OP_GE: r.compare_true = a >= b;
        OP_LE: r.compare_true = a <= b;
        OP_EQ: r.compare_true = a == b;
        OP_NE: r.compare_true = a != b;
        OP_MIN: r.result_value = (a < b) ? a : b;
        OP_MAX: r.result_value = (a > b) ? a : b;
        OP_INC: r.result_value = a + 1;
        OP_DEC: r.result_value = a - 1;
        OP_TO_INT: r.result_value = a >>> FB;
        default: r.result_value = a << FB;
      endcase
      return r;
    endfunction

    function void note_operation(input fpa_in_t x);
      pending.push_back(compute(x));
    endfunction

    task check_result(input fpa_out_t got);
      fpa_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (got.result_value !== want.result_value)
        report_mismatch($sformatf("result_value %h, wanted %h",
                                  got.result_value, want.result_value));
      if (got.compare_true !== want.compare_true)
        report_mismatch($sformatf("compare_true %b, wanted %b",
                                  got.compare_true, want.compare_true));
      if (got.saturated !== want.saturated)
        report_mismatch($sformatf("saturated %b, wanted %b",
                                  got.saturated, want.saturated));
      if (got.divide_by_zero !== want.divide_by_zero)
        report_mismatch($sformatf("divide_by_zero %b, wanted %b",
                                  got.divide_by_zero, want.divide_by_zero));
    endtask

    task report_mismatch(input string msg);
      errors++;
      $display("tb: mismatch: %s", msg);
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  fpa_in_t  in_i;
  logic     out_valid_o;
  logic     out_stall_i;
  fpa_out_t out_o;

  alu_scoreboard alu_sb;
  fpa_in_t       op_queue[$];
  bit            stim_done;
  bit            no_gaps;
  longint        cycle_count;

  localparam int LATENCY = 32 + FB + 2;
  localparam longint CYCLE_LIMIT = 400000;

  fixed_point_alu u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // pick an operand biased towards the awkward corners
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 6)) - 3);
      3: return 32'($signed($urandom_range(0, 4096)) - 2048);
      4: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      5: return 32'($urandom_range(0, 1)) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // queue one operation for the driver
  task push_op(input fpa_op_e op, input logic [31:0] a, input logic [31:0] b);
    fpa_in_t x;
    x.opcode = op;
    x.operand_a = a;
    x.operand_b = b;
    op_queue.push_back(x);
  endtask

  // input driver: hold each beat until accepted, gap at random between beats
  task drive_inputs();
    int gap;
    while (op_queue.size() != 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_i <= op_queue[0];
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      alu_sb.note_operation(op_queue.pop_front());
    end
  endtask

  // output stall: draw a hold per result, sometimes none for long runs
  initial begin : stall_proc
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 12);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // monitor: take a result wherever valid meets no stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) alu_sb.check_result(out_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : main
    int n;
    alu_sb = new();
    cycle_count = 0;
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every opcode on the extremes, plus the special cases
    for (int op = 0; op < 16; op++)
      push_op(fpa_op_e'(op), 32'h8000_0000, 32'h7FFF_FFFF);
    push_op(OP_DIV, 32'h0000_0100, 32'd0);   // positive over zero
    push_op(OP_DIV, 32'hFFFF_FF00, 32'd0);   // negative over zero
    push_op(OP_DIV, 32'd0, 32'd0);           // zero over zero
    push_op(OP_MUL, 32'h0000_0001, 32'h0000_0080); // tie rounds away
    push_op(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080); // negative tie
    push_op(OP_MUL, 32'h8000_0000, 32'h8000_0000); // saturate high
    push_op(OP_DIV, 32'h0000_0001, 32'h0000_0200); // divide tie
    push_op(OP_TO_INT, 32'hFFFF_FFFF, 32'd0);       // floors
    push_op(OP_FROM_INT, 32'h7FFF_FFFF, 32'd0);     // bits shifted out
    drive_inputs();

    // random: mostly gapped, with one burst stretch with no idling
    for (int blk = 0; blk < 11; blk++) begin
      no_gaps = (blk == 5);
      for (n = 0; n < 100; n++)
        push_op(fpa_op_e'($urandom_range(0, 15)), pick_operand(), pick_operand());
      drive_inputs();
    end
    no_gaps = 1'b0;
    in_valid_i <= 1'b0;

    while (alu_sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);

    if (alu_sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
